### rtl/mqpf_pkg.sv
// ----------------------------------------------------------------------------
// mqpf_pkg
// Shared types and constants of the multi-queue strict-priority FIFO.
// ----------------------------------------------------------------------------
package mqpf_pkg;

    // default sizing
    localparam int MAX_QUEUES_DEF  = 8;
    localparam int CLASS_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;

    // fixed field widths
    localparam int NUM_CLASSES = 4;
    localparam int CLASS_W     = 2;
    localparam int QNUM_W      = 4;
    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int QIU_RESET   = 8;

    // s_tdata layout: queue_id, rank_class, person_tag from bit 0 up
    localparam int IN_QNUM_LSB  = 0;
    localparam int IN_CLASS_LSB = 4;
    localparam int IN_TAG_LSB   = 6;
    localparam int IN_DATA_W    = 24;

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // transaction operation carried in tuser
    typedef enum logic {
        OP_ENTER = 1'b0,
        OP_LEAVE = 1'b1
    } op_t;

    // result status carried in tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED     = 3'd0,
        STAT_DEPARTED   = 3'd1,
        STAT_LEAVE_NONE = 3'd2,
        STAT_ENTER_BAD  = 3'd3,
        STAT_CLASS_FULL = 3'd4
    } status_t;

    // control sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_META = 3'b010,
        ST_DATA = 3'b100
    } state_t;

endpackage

### rtl/mqpf_ram.sv
// ----------------------------------------------------------------------------
// mqpf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mqpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/multi_queue_priority_fifo_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_priority_fifo_unit
// Numbered queues, each with four rank classes served in strict priority
// (class 3 first) and first-in first-out within a class.
// ----------------------------------------------------------------------------
// Each transaction gives one result. A transaction naming an invalid queue
// loads its result register at acceptance, without a RAM access. Otherwise
// the per-queue pointer/count row is read from the queue-state RAM,
// modified and written back, and a departing leave then reads its tag from
// the entry RAM before its result is loaded. One transaction is worked on
// at a time; the next one is taken as soon as the result register is free
// or being drained. Queue-state rows carry a valid bit each, cleared at
// reset, so no clearing pass is needed. Tag storage is not initialized;
// only entries counted as filled are read.
// ----------------------------------------------------------------------------
module multi_queue_priority_fifo_unit
    import mqpf_pkg::*;
#(
    parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
    parameter int CLASS_DEPTH = CLASS_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // queue_id[3:0], rank_class[5:4], person_tag[21:6]
    input  logic [0:0]            s_tuser,  // op[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TAG_W-1:0]      m_tdata,  // departed_tag[15:0]
    output logic [STATUS_W-1:0]   m_tuser   // status[2:0]
);

    localparam int QW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int PW  = $clog2(CLASS_DEPTH);
    localparam int CW  = $clog2(CLASS_DEPTH + 1);
    localparam int EW  = CW + 2 * PW;
    localparam int RW  = NUM_CLASSES * EW;
    localparam int SW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int EAW = QW + CLASS_W + PW;
    localparam int ED  = MAX_QUEUES * NUM_CLASSES * (1 << PW);
    localparam int QD  = (MAX_QUEUES > 1) ? MAX_QUEUES : 2;

    // configuration register
    logic [QNUM_W-1:0] qiu_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qiu_reg <= QNUM_W'(QIU_RESET);
        end
        else if (cfg_wr)
        begin
            qiu_reg <= pwdata[QNUM_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (psel && !pwrite && !paddr[2])
        begin
            prdata[QNUM_W-1:0] = qiu_reg;
        end
    end

    // input field decode
    logic [QNUM_W-1:0]  in_qnum;
    logic [CLASS_W-1:0] in_class;
    logic [SW-1:0]      in_tag;
    logic               in_fire;
    logic               in_q_ok;
    logic [QW-1:0]      in_qidx;

    assign in_qnum  = s_tdata[IN_QNUM_LSB +: QNUM_W];
    assign in_class = s_tdata[IN_CLASS_LSB +: CLASS_W];
    assign in_tag   = s_tdata[IN_TAG_LSB +: SW];
    assign in_fire  = s_tvalid && s_tready;
    assign in_q_ok  = (in_qnum != '0) && (in_qnum <= qiu_reg)
                   && ({1'b0, in_qnum} <= (QNUM_W+1)'(MAX_QUEUES));
    assign in_qidx  = QW'(in_qnum - QNUM_W'(1));

    // transaction registers
    state_t             state_reg, state_next;
    logic               op_reg;
    logic [QW-1:0]      qidx_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [SW-1:0]      tag_reg;
    logic [QD-1:0]      row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= s_tuser[0];
            qidx_reg <= in_qidx;
            cls_reg  <= in_class;
            tag_reg  <= in_tag;
        end
    end

    // queue-state RAM: one row per queue, {count, tail, head} per class
    logic [RW-1:0] row_rdata;
    logic [RW-1:0] row_wdata;
    logic          row_we;

    mqpf_ram #(
        .WIDTH (RW),
        .DEPTH (QD)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (qidx_reg),
        .wdata (row_wdata),
        .re    (in_fire && in_q_ok),
        .raddr (in_qidx),
        .rdata (row_rdata)
    );

    // entry RAM: tags, addressed {queue, class, slot}
    logic           ent_we;
    logic           ent_re;
    logic [EAW-1:0] ent_waddr;
    logic [EAW-1:0] ent_raddr;
    logic [SW-1:0]  ent_rdata;

    mqpf_ram #(
        .WIDTH (SW),
        .DEPTH (ED)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (tag_reg),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // row unpack, class pick and row update
    logic [RW-1:0]      row_cur;
    logic [PW-1:0]      head [NUM_CLASSES];
    logic [PW-1:0]      tail [NUM_CLASSES];
    logic [CW-1:0]      cnt  [NUM_CLASSES];
    logic [CLASS_W-1:0] pick;
    logic               any_full;
    logic               class_full;
    logic [PW-1:0]      tail_bump;
    logic [PW-1:0]      head_bump;

    assign row_cur = row_valid_reg[qidx_reg] ? row_rdata : '0;

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head[c] = row_cur[c*EW +: PW];
            tail[c] = row_cur[c*EW + PW +: PW];
            cnt[c]  = row_cur[c*EW + 2*PW +: CW];
        end
    end

    // highest non-empty class
    always_comb
    begin
        pick     = '0;
        any_full = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (cnt[c] != '0)
            begin
                pick     = CLASS_W'(c);
                any_full = 1'b1;
            end
        end
    end

    assign class_full = (cnt[cls_reg] == CW'(CLASS_DEPTH));
    assign tail_bump  = (tail[cls_reg] == PW'(CLASS_DEPTH - 1)) ? '0
                      : tail[cls_reg] + PW'(1);
    assign head_bump  = (head[pick] == PW'(CLASS_DEPTH - 1)) ? '0
                      : head[pick] + PW'(1);

    always_comb
    begin
        row_wdata = row_cur;
        if (op_reg == OP_ENTER)
        begin
            row_wdata[int'(cls_reg)*EW + PW +: PW] = tail_bump;
            row_wdata[int'(cls_reg)*EW + 2*PW +: CW] = cnt[cls_reg] + CW'(1);
        end
        else
        begin
            row_wdata[int'(pick)*EW +: PW] = head_bump;
            row_wdata[int'(pick)*EW + 2*PW +: CW] = cnt[pick] - CW'(1);
        end
    end

    logic in_meta;
    assign in_meta   = (state_reg == ST_META);
    assign row_we    = in_meta && ((op_reg == OP_ENTER) ? !class_full : any_full);
    assign ent_we    = in_meta && (op_reg == OP_ENTER) && !class_full;
    assign ent_re    = in_meta && (op_reg == OP_LEAVE) && any_full;
    assign ent_waddr = {qidx_reg, cls_reg, tail[cls_reg]};
    assign ent_raddr = {qidx_reg, pick, head[pick]};

    // row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (row_we)
        begin
            row_valid_reg[qidx_reg] <= 1'b1;
        end
    end

    // sequencer and result register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic              out_load;
    logic [TAG_W-1:0]  dep_tag;

    always_comb
    begin
        dep_tag         = '0;
        dep_tag[SW-1:0] = ent_rdata;
    end

    always_comb
    begin
        state_next      = state_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_q_ok)
                    begin
                        state_next = ST_META;
                    end
                    else
                    begin
                        out_load        = 1'b1;
                        out_tag_next    = '0;
                        out_status_next = (s_tuser[0] == OP_LEAVE) ? STAT_LEAVE_NONE
                                                                   : STAT_ENTER_BAD;
                    end
                end
            end
            ST_META:
            begin
                if ((op_reg == OP_LEAVE) && any_full)
                begin
                    state_next = ST_DATA;
                end
                else
                begin
                    state_next   = ST_IDLE;
                    out_load     = 1'b1;
                    out_tag_next = '0;
                    if (op_reg == OP_LEAVE)
                    begin
                        out_status_next = STAT_LEAVE_NONE;
                    end
                    else
                    begin
                        out_status_next = class_full ? STAT_CLASS_FULL : STAT_STORED;
                    end
                end
            end
            ST_DATA:
            begin
                state_next      = ST_IDLE;
                out_load        = 1'b1;
                out_tag_next    = dep_tag;
                out_status_next = STAT_DEPARTED;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !m_tready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
        end
    end

    // handshake outputs
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = out_status_reg;

endmodule

### rtl/mqpf_checker.sv
// ----------------------------------------------------------------------------
// mqpf_checker
// Port-level checks of the multi-queue strict-priority FIFO, bound to the
// top level.
// ----------------------------------------------------------------------------
module mqpf_checker
    import mqpf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_DATA_W-1:0] s_tdata,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TAG_W-1:0]     m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // departed tag is zero unless someone departed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_DEPARTED) |-> m_tdata == '0)
        else $error("nonzero tag without departure");

    // queue number zero is answered in the next cycle with an error status
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[IN_QNUM_LSB +: QNUM_W] == '0)
        |=> m_tvalid && (m_tuser == ($past(s_tuser[0]) ? STAT_LEAVE_NONE
                                                        : STAT_ENTER_BAD)))
        else $error("invalid queue not reported");

    // no new transaction is taken while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind multi_queue_priority_fifo_unit mqpf_checker u_mqpf_checker (.*);

### sim/mqpf_checker.sv
// ----------------------------------------------------------------------------
// mqpf_scoreboard
// Scoreboard for the multi-queue strict-priority FIFO: tracks queue contents
// and the queue-count register, predicts one result per input transaction
// and compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module mqpf_scoreboard
    import mqpf_pkg::*;
#(
    parameter logic [APB_ADDR_W-1:0] QIU_ADDR = '0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TAG_W-1:0]      m_tdata,
    input  logic [STATUS_W-1:0]   m_tuser,
    output int                    mismatch_count,
    output int                    results_outstanding
);

    localparam int NUM_FIFOS = MAX_QUEUES_DEF * NUM_CLASSES;
    localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((33'd1 << TAG_BITS_DEF) - 33'd1);

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
    } result_t;

    // shadow of the queue state
    logic [TAG_W-1:0] tag_store [NUM_FIFOS][CLASS_DEPTH_DEF];
    int unsigned      head_idx  [NUM_FIFOS];
    int unsigned      tail_idx  [NUM_FIFOS];
    int unsigned      fill_cnt  [NUM_FIFOS];
    logic [3:0]       queues_in_use;

    result_t          expected_results [$];
    result_t          oldest;
    int               mismatches;

    // queue numbers run from 1 to the register value, capped at MAX_QUEUES
    function automatic bit queue_valid(logic [QNUM_W-1:0] qnum);
        int lim;
        lim = (queues_in_use > MAX_QUEUES_DEF) ? MAX_QUEUES_DEF : int'(queues_in_use);
        return (qnum >= 1) && (int'(qnum) <= lim);
    endfunction

    // update the shadow state for one transaction and queue its result
    task automatic predict_service(op_t op, logic [QNUM_W-1:0] qnum,
                                   logic [CLASS_W-1:0] cls, logic [TAG_W-1:0] tag);
        result_t r;
        int      f;
        int      c;
        bit      found;
        r.status = STAT_LEAVE_NONE;
        r.tag    = '0;
        found    = 1'b0;
        if (!queue_valid(qnum))
        begin
            r.status = (op == OP_LEAVE) ? STAT_LEAVE_NONE : STAT_ENTER_BAD;
        end
        else if (op == OP_ENTER)
        begin
            f = (int'(qnum) - 1) * NUM_CLASSES + int'(cls);
            if (fill_cnt[f] >= CLASS_DEPTH_DEF)
            begin
                r.status = STAT_CLASS_FULL;
            end
            else
            begin
                tag_store[f][tail_idx[f]] = tag & TAG_MASK;
                tail_idx[f] = (tail_idx[f] + 1) % CLASS_DEPTH_DEF;
                fill_cnt[f]++;
                r.status = STAT_STORED;
            end
        end
        else
        begin
            // highest non-empty class wins, oldest entry within it
            for (c = NUM_CLASSES - 1; c >= 0 && !found; c--)
            begin
                f = (int'(qnum) - 1) * NUM_CLASSES + c;
                if (fill_cnt[f] != 0)
                begin
                    r.tag    = tag_store[f][head_idx[f]];
                    r.status = STAT_DEPARTED;
                    head_idx[f] = (head_idx[f] + 1) % CLASS_DEPTH_DEF;
                    fill_cnt[f]--;
                    found = 1'b1;
                end
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (head_idx[i])
            begin
                head_idx[i] = 0;
                tail_idx[i] = 0;
                fill_cnt[i] = 0;
            end
            queues_in_use = QNUM_W'(QIU_RESET);
            expected_results.delete();
            mismatches = 0;
            mismatch_count      <= 0;
            results_outstanding <= 0;
        end
        else
        begin
            // results first, so a same-edge input cannot satisfy them
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d departed_tag %0h", m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (m_tuser !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== oldest.tag)
                    begin
                        $error("departed_tag: expected %0h, actual %0h", oldest.tag, m_tdata);
                        mismatches++;
                    end
                end
            end

            // register write at the access edge
            if (psel && penable && pwrite && pready && paddr == QIU_ADDR)
                queues_in_use = pwdata[3:0];

            if (s_tvalid && s_tready)
                predict_service(op_t'(s_tuser[0]), s_tdata[IN_QNUM_LSB +: QNUM_W],
                                s_tdata[IN_CLASS_LSB +: CLASS_W],
                                s_tdata[IN_TAG_LSB +: TAG_W]);

            mismatch_count      <= mismatches;
            results_outstanding <= expected_results.size();
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for multi_queue_priority_fifo_unit: directed corner
// transactions, then random enter/leave bursts over several queue-count
// settings with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import mqpf_pkg::*;

    localparam logic [APB_ADDR_W-1:0] QIU_ADDR = APB_ADDR_W'(4 * 0);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 240;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // queue_id[3:0], rank_class[5:4], person_tag[21:6]
    logic [0:0]            s_tuser;   // op[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TAG_W-1:0]      m_tdata;   // departed_tag[15:0]
    logic [STATUS_W-1:0]   m_tuser;   // status[2:0]

    int mismatch_count;
    int results_outstanding;
    int idle_cycles;
    int tx_burst_left;
    int tx_gap_max;

    multi_queue_priority_fifo_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mqpf_scoreboard #(
        .QIU_ADDR (QIU_ADDR)
    ) u_scoreboard (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // idle-cycle ceiling for the next stretch: none, light or heavy
    function automatic int pick_idle_cap();
        int roll;
        roll = $urandom_range(0, 2);
        return (roll == 0) ? 0 : (roll == 1) ? 3 : 12;
    endfunction

    // result side: random stall before each transaction
    initial
    begin
        int burst_left;
        int stall_max;
        int stall;
        burst_left = 0;
        stall_max  = 0;
        m_tready   = 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (burst_left == 0)
            begin
                stall_max  = pick_idle_cap();
                burst_left = $urandom_range(10, 40);
            end
            burst_left--;
            stall = $urandom_range(0, stall_max);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // watchdog: cycles without any transaction or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multi_queue_priority_fifo_unit: mismatch");
            $finish;
        end
    end

    task automatic send_item(op_t op, logic [QNUM_W-1:0] qnum,
                             logic [CLASS_W-1:0] cls, logic [TAG_W-1:0] tag);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_gap_max    = pick_idle_cap();
            tx_burst_left = $urandom_range(10, 40);
        end
        tx_burst_left--;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, tag, cls, qnum};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop the input, let all results out, then let the pipeline empty
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random bursts: fill, drain or mixed, mostly around one hot queue/class
    task automatic run_random_phase(int n_items, int live_queues);
        int          burst_left;
        int          enter_pct;
        int          roll;
        logic [3:0]  hot_q;
        logic [1:0]  hot_cls;
        logic [3:0]  qnum;
        logic [1:0]  cls;
        op_t         op;
        burst_left = 0;
        enter_pct  = 50;
        hot_q      = 4'd1;
        hot_cls    = 2'd0;
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left == 0)
            begin
                roll       = $urandom_range(0, 2);
                enter_pct  = (roll == 0) ? 80 : (roll == 1) ? 20 : 50;
                hot_q      = (live_queues > 0) ? 4'($urandom_range(1, live_queues)) : 4'd1;
                hot_cls    = 2'($urandom_range(0, 3));
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            op   = ($urandom_range(0, 99) < enter_pct) ? OP_ENTER : OP_LEAVE;
            roll = $urandom_range(0, 99);
            if (roll < 8 || live_queues == 0)
                qnum = 4'($urandom_range(0, 15));
            else if (roll < 60)
                qnum = hot_q;
            else
                qnum = 4'($urandom_range(1, live_queues));
            cls = ($urandom_range(0, 1) != 0) ? hot_cls : 2'($urandom_range(0, 3));
            send_item(op, qnum, cls, 16'($urandom));
        end
    endtask

    initial
    begin
        int qiu_plan [8];
        int live;
        qiu_plan = '{1, 0, 15, 3, 8, 5, 2, 8};
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        tx_burst_left = 0;
        tx_gap_max    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: invalid and empty queues, class priority, FIFO order
        send_item(OP_LEAVE, 4'd1,  2'd0, 16'h0000);
        send_item(OP_ENTER, 4'd0,  2'd1, 16'h1111);
        send_item(OP_ENTER, 4'd9,  2'd2, 16'h2222);
        send_item(OP_ENTER, 4'd15, 2'd3, 16'hFFFF);
        send_item(OP_LEAVE, 4'd0,  2'd3, 16'hFFFF);
        send_item(OP_ENTER, 4'd1,  2'd0, 16'h0000);
        send_item(OP_ENTER, 4'd1,  2'd3, 16'hFFFF);
        send_item(OP_ENTER, 4'd1,  2'd1, 16'h5A5A);
        send_item(OP_ENTER, 4'd1,  2'd3, 16'h0001);
        send_item(OP_LEAVE, 4'd1,  2'd0, 16'h0000);
        send_item(OP_LEAVE, 4'd1,  2'd0, 16'h0000);
        // top queue, one class filled past its depth
        for (int i = 0; i <= CLASS_DEPTH_DEF; i++)
            send_item(OP_ENTER, 4'd8, 2'd2, 16'(16'hA000 + i));

        // random phases, each under its own queue count
        foreach (qiu_plan[p])
        begin
            wait_quiet();
            apb_write(QIU_ADDR, APB_DATA_W'(qiu_plan[p]));
            live = (qiu_plan[p] > MAX_QUEUES_DEF) ? MAX_QUEUES_DEF : qiu_plan[p];
            run_random_phase((live == 0) ? PHASE_ITEMS / 4 : PHASE_ITEMS, live);
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("multi_queue_priority_fifo_unit: match");
        else
            $display("multi_queue_priority_fifo_unit: mismatch");
        $finish;
    end

endmodule
